FILE: rtl/hgn_pkg.sv
package hgn_pkg;

    // largest image side, as log2 of pixels
    localparam int HGN_MAX_DIM_LOG2 = 8;
    localparam int HGN_DIV_STEPS    = 16;

    localparam logic HGN_OP_LOAD  = 1'b0;
    localparam logic HGN_OP_FETCH = 1'b1;

    localparam logic [1:0] HGN_FMT_SIGNED = 2'd0;
    localparam logic [1:0] HGN_FMT_OFFSET = 2'd1;
    localparam logic [1:0] HGN_FMT_RGBA   = 2'd2;

    localparam logic [2:0] HGN_CFG_WIDTH_LOG2  = 3'd0;
    localparam logic [2:0] HGN_CFG_HEIGHT_LOG2 = 3'd1;
    localparam logic [2:0] HGN_CFG_OUT_FORMAT  = 3'd2;
    localparam logic [2:0] HGN_CFG_ABSOLUTE    = 3'd3;
    localparam logic [2:0] HGN_CFG_NORMALIZE   = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [31:0] height_pixel;
    } hgn_in_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic        last_pixel;
        logic [7:0]  highest_delta;
    } hgn_out_t;

    typedef struct packed {
        logic load;
        logic step;
    } hgn_div_ctrl_t;

    typedef struct packed {
        logic mag_path;
        logic offset;
    } hgn_mode_t;

    typedef enum logic [3:0] {
        HGN_IDLE,
        HGN_GRAD,
        HGN_MAX,
        HGN_MAX_END,
        HGN_NRM_RD,
        HGN_NRM_LD,
        HGN_NRM_DIV,
        HGN_NRM_WR,
        HGN_FRD,
        HGN_FOUT
    } hgn_state_t;

    // pack one central difference into a stored byte
    function automatic logic [7:0] hgn_pack(logic signed [8:0] d, logic [1:0] fmt,
                                            logic abs_en);
        logic signed [8:0] nd;
        nd = -d;
        if (fmt != HGN_FMT_SIGNED)
            return d[7:0] ^ 8'h80;
        else if (abs_en)
            return d[8] ? nd[7:0] : d[7:0];
        else
            return d[7:0];
    endfunction

    // magnitude of a stored byte as used by the maximum search
    function automatic logic [7:0] hgn_mag(logic [7:0] b, hgn_mode_t mode);
        logic [7:0] sb;
        logic [7:0] nb;
        sb = mode.offset ? (b ^ 8'h80) : b;
        nb = 8'h00 - sb;
        if (mode.mag_path)
            return b;
        else
            return sb[7] ? nb : sb;
    endfunction

endpackage

FILE: rtl/heightmap_gradient_normalizer_unit.sv
// heightmap gradient normalizer
// loads store the green byte of each RGBA word into a height memory in raster
// order; fetches return gradient pixels in raster order
// command channel: cmd is taken at a clock edge with start high and busy low
// result channel: done marks result for one cycle; the receiver cannot stall it
// configuration: cfg_we/cfg_index/cfg_data, written only while idle by the user
// (the block does not enforce it); a write to indices 0 to 4 restarts loading
// and fetching and forces a recompute; a load writes the height memory when taken;
// a fetch of an already computed image goes to HGN_FOUT, where done shows the result
// the first fetch after a load or configuration write runs the frame passes:
// the gradient build (four height memory reads per pixel over a single read
// port), then with normalization the maximum search and, unless the maximum is
// zero, scaling per pixel (16-step divider), then HGN_FRD and HGN_FOUT
// reset clears indices and flags and presets configuration; memories are not cleared
module heightmap_gradient_normalizer_unit
    import hgn_pkg::*;
#(
    parameter int MAX_DIM_LOG2 = HGN_MAX_DIM_LOG2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  hgn_in_t    cmd,
    output logic       done,
    output hgn_out_t   result,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int AW    = 2 * MAX_DIM_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam logic [3:0] DIM_MAX   = 4'(MAX_DIM_LOG2);
    localparam logic [3:0] DIM_RESET = (MAX_DIM_LOG2 < 8) ? DIM_MAX : 4'd8;
    localparam logic [3:0] DIV_LAST  = 4'(HGN_DIV_STEPS - 1);

    hgn_state_t state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [7:0]    hxp_reg, hxp_next;
    logic [7:0]    hxm_reg, hxm_next;
    logic [7:0]    hyp_reg, hyp_next;
    logic          pend_reg, pend_next;
    logic [7:0]    top_reg, top_next;
    logic [7:0]    max_delta_reg, max_delta_next;
    logic          computed_reg, computed_next;
    logic [AW-1:0] load_idx_reg, load_idx_next;
    logic [AW-1:0] fetch_idx_reg, fetch_idx_next;
    logic [3:0]    w_log2_reg, w_log2_next;
    logic [3:0]    h_log2_reg, h_log2_next;
    logic [1:0]    fmt_reg, fmt_next;
    logic          abs_reg, abs_next;
    logic          norm_reg, norm_next;

    logic          h_we;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [7:0]    h_wdata, h_rdata;
    logic          g_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [15:0]   g_wdata, g_rdata;

    logic [4:0]    dim_sum;
    logic [AW-1:0] wmask, imask, hi_bits, lo_bits, row_step;
    logic [AW-1:0] a_xp, a_xm, a_yp, a_ym;
    logic signed [8:0] ds, dt;
    logic [15:0]   grad_build, scaled;
    logic [7:0]    m0, m1, top_scan;
    logic [3:0]    cfg_dim;
    logic          k_last;
    hgn_mode_t     mode;
    hgn_div_ctrl_t div_ctrl;

    // storage
    hgn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_height_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    hgn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_grad_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    hgn_scale u_scale (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .mode      (mode),
        .grad_word (g_rdata),
        .top       (top_reg),
        .scaled    (scaled)
    );

    // image masks and wrapped neighbor addresses
    assign dim_sum  = {1'b0, w_log2_reg} + {1'b0, h_log2_reg};
    assign wmask    = ~({AW{1'b1}} << w_log2_reg);
    assign imask    = ~({AW{1'b1}} << dim_sum);
    assign hi_bits  = k_reg & ~wmask;
    assign lo_bits  = k_reg & wmask;
    assign row_step = AW'(1) << w_log2_reg;
    assign a_xp     = hi_bits | ((k_reg + AW'(1)) & wmask);
    assign a_xm     = hi_bits | ((k_reg - AW'(1)) & wmask);
    assign a_yp     = lo_bits | ((k_reg + row_step) & imask & ~wmask);
    assign a_ym     = lo_bits | ((k_reg - row_step) & imask & ~wmask);
    assign k_last   = (k_reg == imask);

    assign mode.mag_path = (fmt_reg < HGN_FMT_RGBA) & abs_reg;
    assign mode.offset   = (fmt_reg != HGN_FMT_SIGNED);

    // gradient of the current pixel, last neighbor straight from memory
    assign ds = $signed({1'b0, hxp_reg}) - $signed({1'b0, hxm_reg});
    assign dt = $signed({1'b0, hyp_reg}) - $signed({1'b0, h_rdata});
    assign grad_build = {hgn_pack(dt, fmt_reg, abs_reg), hgn_pack(ds, fmt_reg, abs_reg)};

    // running maximum over the gradient memory
    assign m0 = hgn_mag(g_rdata[7:0], mode);
    assign m1 = hgn_mag(g_rdata[15:8], mode);
    always_comb
    begin
        top_scan = top_reg;
        if (m0 > top_scan)
        begin
            top_scan = m0;
        end
        if (m1 > top_scan)
        begin
            top_scan = m1;
        end
    end

    assign cfg_dim = (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= HGN_IDLE;
            k_reg         <= '0;
            phase_reg     <= 3'd0;
            cnt_reg       <= 4'd0;
            pend_reg      <= 1'b0;
            top_reg       <= 8'h00;
            max_delta_reg <= 8'h00;
            computed_reg  <= 1'b0;
            load_idx_reg  <= '0;
            fetch_idx_reg <= '0;
            w_log2_reg    <= DIM_RESET;
            h_log2_reg    <= DIM_RESET;
            fmt_reg       <= HGN_FMT_SIGNED;
            abs_reg       <= 1'b0;
            norm_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            top_reg       <= top_next;
            max_delta_reg <= max_delta_next;
            computed_reg  <= computed_next;
            load_idx_reg  <= load_idx_next;
            fetch_idx_reg <= fetch_idx_next;
            w_log2_reg    <= w_log2_next;
            h_log2_reg    <= h_log2_next;
            fmt_reg       <= fmt_next;
            abs_reg       <= abs_next;
            norm_reg      <= norm_next;
        end
    end

    // neighbor heights captured during the build
    always_ff @(posedge clk)
    begin
        hxp_reg <= hxp_next;
        hxm_reg <= hxm_next;
        hyp_reg <= hyp_next;
    end

    // sequencer: next state, memory ports and outputs
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        hxp_next       = hxp_reg;
        hxm_next       = hxm_reg;
        hyp_next       = hyp_reg;
        pend_next      = 1'b0;
        top_next       = pend_reg ? top_scan : top_reg;
        max_delta_next = max_delta_reg;
        computed_next  = computed_reg;
        load_idx_next  = load_idx_reg;
        fetch_idx_next = fetch_idx_reg;
        w_log2_next    = w_log2_reg;
        h_log2_next    = h_log2_reg;
        fmt_next       = fmt_reg;
        abs_next       = abs_reg;
        norm_next      = norm_reg;
        h_we           = 1'b0;
        h_waddr        = load_idx_reg;
        h_wdata        = cmd.height_pixel[15:8];
        g_we           = 1'b0;
        g_waddr        = k_reg;
        g_wdata        = grad_build;
        g_raddr        = fetch_idx_reg;
        div_ctrl       = '0;
        done           = 1'b0;

        case (phase_reg)
            3'd0:    h_raddr = a_xp;
            3'd1:    h_raddr = a_xm;
            3'd2:    h_raddr = a_yp;
            default: h_raddr = a_ym;
        endcase

        unique case (state_reg)
            HGN_IDLE:
            begin
                if (start)
                begin
                    if (cmd.operation == HGN_OP_LOAD)
                    begin
                        h_we           = 1'b1;
                        load_idx_next  = (load_idx_reg + AW'(1)) & imask;
                        computed_next  = 1'b0;
                        fetch_idx_next = '0;
                    end
                    else if (computed_reg)
                    begin
                        state_next = HGN_FOUT;
                    end
                    else
                    begin
                        k_next     = '0;
                        phase_next = 3'd0;
                        state_next = HGN_GRAD;
                    end
                end
            end
            HGN_GRAD:
            begin
                case (phase_reg)
                    3'd1:    hxp_next = h_rdata;
                    3'd2:    hxm_next = h_rdata;
                    3'd3:    hyp_next = h_rdata;
                    default: ;
                endcase
                if (phase_reg == 3'd4)
                begin
                    g_we       = 1'b1;
                    phase_next = 3'd0;
                    if (k_last)
                    begin
                        k_next   = '0;
                        top_next = 8'h00;
                        if (norm_reg)
                        begin
                            state_next = HGN_MAX;
                        end
                        else
                        begin
                            max_delta_next = 8'h00;
                            computed_next  = 1'b1;
                            state_next     = HGN_FRD;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            HGN_MAX:
            begin
                g_raddr   = k_reg;
                pend_next = 1'b1;
                if (k_last)
                begin
                    state_next = HGN_MAX_END;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            HGN_MAX_END:
            begin
                if (top_next == 8'h00)
                begin
                    max_delta_next = 8'h00;
                    computed_next  = 1'b1;
                    state_next     = HGN_FRD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = HGN_NRM_RD;
                end
            end
            HGN_NRM_RD:
            begin
                g_raddr    = k_reg;
                state_next = HGN_NRM_LD;
            end
            HGN_NRM_LD:
            begin
                div_ctrl.load = 1'b1;
                cnt_next      = 4'd0;
                state_next    = HGN_NRM_DIV;
            end
            HGN_NRM_DIV:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = HGN_NRM_WR;
                end
            end
            HGN_NRM_WR:
            begin
                g_we    = 1'b1;
                g_wdata = scaled;
                if (k_last)
                begin
                    max_delta_next = top_reg;
                    computed_next  = 1'b1;
                    state_next     = HGN_FRD;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = HGN_NRM_RD;
                end
            end
            HGN_FRD:
            begin
                state_next = HGN_FOUT;
            end
            HGN_FOUT:
            begin
                done           = 1'b1;
                fetch_idx_next = (fetch_idx_reg + AW'(1)) & imask;
                state_next     = HGN_IDLE;
            end
            default:
            begin
                state_next = HGN_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                HGN_CFG_WIDTH_LOG2:  w_log2_next = cfg_dim;
                HGN_CFG_HEIGHT_LOG2: h_log2_next = cfg_dim;
                HGN_CFG_OUT_FORMAT:  fmt_next    = cfg_data[1:0];
                HGN_CFG_ABSOLUTE:    abs_next    = cfg_data[0];
                HGN_CFG_NORMALIZE:   norm_next   = cfg_data[0];
                default: ;
            endcase
            if (cfg_index <= HGN_CFG_NORMALIZE)
            begin
                computed_next  = 1'b0;
                load_idx_next  = '0;
                fetch_idx_next = '0;
            end
        end
    end

    assign busy = (state_reg != HGN_IDLE);

    // result transfer
    assign result.out_word      = {((fmt_reg >= HGN_FMT_RGBA) ? 8'hff : 8'h00), 8'h00, g_rdata};
    assign result.last_pixel    = (fetch_idx_reg == imask);
    assign result.highest_delta = max_delta_reg;

    // a load never produces a result transfer
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.operation == HGN_OP_LOAD) |=> !done)
        else $error("result after load");

    // results are isolated single-cycle transfers
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

    // no normalization means a zero highest delta
    a_no_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !norm_reg) |-> (result.highest_delta == 8'h00))
        else $error("highest delta without normalization");

    // a result only ends a busy period
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");

endmodule

FILE: rtl/hgn_ram.sv
module hgn_ram
    import hgn_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/hgn_scale.sv
module hgn_scale
    import hgn_pkg::*;
(
    input  logic          clk,
    input  hgn_div_ctrl_t ctrl,
    input  hgn_mode_t     mode,
    input  logic [15:0]   grad_word,
    input  logic [7:0]    top,
    output logic [15:0]   scaled
);

    for (genvar i = 0; i < 2; i++)
    begin : g_lane
        logic [7:0]  b;
        logic [7:0]  sb;
        logic [7:0]  magv;
        logic [15:0] num;
        logic [15:0] num_reg;
        logic [7:0]  rem_reg;
        logic [15:0] quo_reg;
        logic        neg_reg;
        logic [8:0]  trial;
        logic        ge;
        logic [8:0]  diff;
        logic [7:0]  qc;
        logic [7:0]  r;

        // numerator: b*255 on the magnitude path, |s|*127 otherwise
        assign b    = grad_word[8*i +: 8];
        assign sb   = mode.offset ? (b ^ 8'h80) : b;
        assign magv = sb[7] ? (8'h00 - sb) : sb;
        assign num  = mode.mag_path ? (({8'h00, b} << 8) - {8'h00, b})
                                    : (({8'h00, magv} << 7) - {8'h00, magv});

        // restoring divide, one quotient bit per step
        assign trial = {rem_reg, num_reg[15]};
        assign ge    = trial >= {1'b0, top};
        assign diff  = trial - {1'b0, top};

        always_ff @(posedge clk)
        begin
            if (ctrl.load)
            begin
                num_reg <= num;
                rem_reg <= 8'h00;
                quo_reg <= 16'h0000;
                neg_reg <= ~mode.mag_path & sb[7];
            end
            else if (ctrl.step)
            begin
                num_reg <= {num_reg[14:0], 1'b0};
                rem_reg <= ge ? diff[7:0] : trial[7:0];
                quo_reg <= {quo_reg[14:0], ge};
            end
        end

        // clamp, restore sign and offset
        always_comb
        begin
            if (neg_reg)
            begin
                qc = (quo_reg > 16'd128) ? 8'd128 : quo_reg[7:0];
                r  = 8'h00 - qc;
            end
            else
            begin
                qc = (quo_reg > 16'd127) ? 8'd127 : quo_reg[7:0];
                r  = qc;
            end
        end

        assign scaled[8*i +: 8] = mode.mag_path ? quo_reg[7:0]
                                                : (mode.offset ? (r ^ 8'h80) : r);
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import hgn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1 << (2 * HGN_MAX_DIM_LOG2);
    localparam int ITEM_TARGET = 1700;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    hgn_in_t    cmd;
    logic       done;
    hgn_out_t   result;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [3:0] cfg_data;

    heightmap_gradient_normalizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // gradient model state
    logic [7:0]  height_mem [STORE_DEPTH];
    logic [15:0] slope_mem [STORE_DEPTH];
    int          load_pos;
    int          fetch_pos;
    logic [7:0]  peak_delta;
    bit          slopes_valid;
    int          w_log2;
    int          h_log2;
    int          fmt;
    int          abs_on;
    int          norm_on;

    hgn_in_t  pending_cmds [$];
    hgn_out_t expected_pixels [$];
    bit       failed;
    bit       cmd_taken;
    int       issued;
    int       burst_left;
    int       gap_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int pixel_count();
        return 1 << (w_log2 + h_log2);
    endfunction

    function automatic int height_of(int x, int y);
        int xm;
        int ym;
        xm = x & ((1 << w_log2) - 1);
        ym = y & ((1 << h_log2) - 1);
        return height_mem[(xm + (ym << w_log2)) & (STORE_DEPTH - 1)];
    endfunction

    function automatic logic [7:0] pack_delta(int d);
        if (fmt != 0)
            return 8'(d + 128);
        if (abs_on != 0)
            return 8'(d < 0 ? -d : d);
        return 8'(d);
    endfunction

    function automatic logic [7:0] scale_signed_byte(logic [7:0] b, int top, bit offset);
        logic [7:0] sb;
        int s;
        int q;
        int r;
        sb = offset ? (b ^ 8'h80) : b;
        s = int'($signed(sb));
        q = (s < 0 ? -s : s) * 127 / top;
        if (s < 0)
        begin
            if (q > 128)
                q = 128;
            r = -q;
        end
        else
        begin
            if (q > 127)
                q = 127;
            r = q;
        end
        return 8'(r + (offset ? 128 : 0));
    endfunction

    function automatic int byte_magnitude(logic [7:0] b, bit mag_path, bit offset);
        logic [7:0] sb;
        int s;
        if (mag_path)
            return b;
        sb = offset ? (b ^ 8'h80) : b;
        s = int'($signed(sb));
        return s < 0 ? -s : s;
    endfunction

    // gradient build followed by optional normalization
    function automatic void compute_slopes();
        int w;
        int h;
        int top;
        int ds;
        int dt;
        int m0;
        int m1;
        bit mag_path;
        bit offset;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] n0;
        logic [7:0] n1;
        w = 1 << w_log2;
        h = 1 << h_log2;
        top = 0;
        mag_path = (fmt < 2) && (abs_on != 0);
        offset = (fmt != 0);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                ds = height_of(x + 1, y) - height_of(x - 1, y);
                dt = height_of(x, y + 1) - height_of(x, y - 1);
                slope_mem[x + (y << w_log2)] = {pack_delta(dt), pack_delta(ds)};
            end
        end
        peak_delta = 8'd0;
        if (norm_on == 0)
            return;
        for (int k = 0; k < pixel_count(); k++)
        begin
            m0 = byte_magnitude(slope_mem[k][7:0], mag_path, offset);
            m1 = byte_magnitude(slope_mem[k][15:8], mag_path, offset);
            if (m0 > top)
                top = m0;
            if (m1 > top)
                top = m1;
        end
        if (top == 0)
            return;
        for (int k = 0; k < pixel_count(); k++)
        begin
            b0 = slope_mem[k][7:0];
            b1 = slope_mem[k][15:8];
            if (mag_path)
            begin
                n0 = 8'(b0 * 255 / top);
                n1 = 8'(b1 * 255 / top);
            end
            else
            begin
                n0 = scale_signed_byte(b0, top, offset);
                n1 = scale_signed_byte(b1, top, offset);
            end
            slope_mem[k] = {n1, n0};
        end
        peak_delta = 8'(top);
    endfunction

    // model update for one accepted command
    function automatic void predict_pixel(hgn_in_t c);
        int size;
        int idx;
        hgn_out_t px;
        size = pixel_count();
        if (c.operation == HGN_OP_LOAD)
        begin
            idx = load_pos & (size - 1);
            height_mem[idx] = c.height_pixel[15:8];
            load_pos = (idx + 1) & (size - 1);
            slopes_valid = 1'b0;
            fetch_pos = 0;
            return;
        end
        if (!slopes_valid)
        begin
            compute_slopes();
            slopes_valid = 1'b1;
        end
        idx = fetch_pos & (size - 1);
        px.out_word = {16'h0000, slope_mem[idx]};
        if (fmt >= 2)
            px.out_word[31:24] = 8'hff;
        px.last_pixel = (idx == size - 1);
        px.highest_delta = peak_delta;
        expected_pixels.push_back(px);
        fetch_pos = (idx + 1) & (size - 1);
    endfunction

    function automatic void model_write_reg(logic [2:0] idx, logic [3:0] val);
        case (idx)
            HGN_CFG_WIDTH_LOG2:  w_log2 = (val > HGN_MAX_DIM_LOG2) ? HGN_MAX_DIM_LOG2 : val;
            HGN_CFG_HEIGHT_LOG2: h_log2 = (val > HGN_MAX_DIM_LOG2) ? HGN_MAX_DIM_LOG2 : val;
            HGN_CFG_OUT_FORMAT:  fmt = val[1:0];
            HGN_CFG_ABSOLUTE:    abs_on = val[0];
            HGN_CFG_NORMALIZE:   norm_on = val[0];
            default:             return;
        endcase
        slopes_valid = 1'b0;
        load_pos = 0;
        fetch_pos = 0;
    endfunction

    // accepted transfers and result checks
    always @(posedge clk)
    begin
        hgn_out_t want;
        cmd_taken = rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t unexpected pixel %h", $time, result);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result.out_word !== want.out_word)
                    begin
                        $display("%0t out_word exp %h got %h", $time,
                                 want.out_word, result.out_word);
                        failed = 1'b1;
                    end
                    if (result.last_pixel !== want.last_pixel)
                    begin
                        $display("%0t last_pixel exp %b got %b", $time,
                                 want.last_pixel, result.last_pixel);
                        failed = 1'b1;
                    end
                    if (result.highest_delta !== want.highest_delta)
                    begin
                        $display("%0t highest_delta exp %h got %h", $time,
                                 want.highest_delta, result.highest_delta);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy)
                predict_pixel(cmd);
        end
    end

    // command driver: bursts separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_taken))
        begin
            if (gap_left > 0 || pending_cmds.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        model_write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int wl, int hl, int f, int a, int n);
        write_reg(HGN_CFG_WIDTH_LOG2, 4'(wl));
        write_reg(HGN_CFG_HEIGHT_LOG2, 4'(hl));
        write_reg(HGN_CFG_OUT_FORMAT, 4'(f));
        write_reg(HGN_CFG_ABSOLUTE, 4'(a));
        write_reg(HGN_CFG_NORMALIZE, 4'(n));
    endtask

    task automatic queue_cmd(logic op, logic [31:0] word);
        hgn_in_t c;
        c.operation = op;
        c.height_pixel = word;
        pending_cmds.push_back(c);
        issued++;
    endtask

    // let the block drain before touching registers
    task automatic drain();
        wait (pending_cmds.size() == 0 && start == 1'b0);
        wait (expected_pixels.size() == 0);
        repeat (40) @(posedge clk);
        wait (busy == 1'b0);
    endtask

    task automatic load_frame();
        for (int i = 0; i < pixel_count(); i++)
            queue_cmd(HGN_OP_LOAD, $urandom());
    endtask

    initial
    begin
        int wl;
        int hl;
        int size;
        int nfetch;
        failed = 1'b0;
        cmd_taken = 1'b0;
        issued = 0;
        burst_left = 8;
        gap_left = 0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        w_log2 = HGN_MAX_DIM_LOG2;
        h_log2 = HGN_MAX_DIM_LOG2;
        fmt = 0;
        abs_on = 0;
        norm_on = 1;
        load_pos = 0;
        fetch_pos = 0;
        peak_delta = 8'd0;
        slopes_valid = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extreme heights on a 2x2 image, signed with normalization
        configure(1, 1, HGN_FMT_SIGNED, 0, 1);
        queue_cmd(HGN_OP_LOAD, 32'h0000ff00);
        queue_cmd(HGN_OP_LOAD, 32'hffffffff);
        queue_cmd(HGN_OP_LOAD, 32'h00000000);
        queue_cmd(HGN_OP_LOAD, 32'hffff00ff);
        for (int i = 0; i < 5; i++)
            queue_cmd(HGN_OP_FETCH, $urandom());
        drain();
        // format three acts as rgba, unnormalized, heights kept from before
        configure(1, 1, 3, 1, 0);
        for (int i = 0; i < 4; i++)
            queue_cmd(HGN_OP_FETCH, $urandom());
        drain();
        // flat image, offset format with absolute set: every stored byte and the maximum are 0x80
        configure(1, 1, HGN_FMT_OFFSET, 1, 1);
        for (int i = 0; i < 4; i++)
            queue_cmd(HGN_OP_LOAD, 32'h12345612);
        for (int i = 0; i < 5; i++)
            queue_cmd(HGN_OP_FETCH, 32'h0);
        drain();

        // random phases
        while (issued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    wl = $urandom_range(8, 15);
                    hl = 0;
                end
                1:
                begin
                    wl = 0;
                    hl = $urandom_range(8, 15);
                end
                default:
                begin
                    wl = $urandom_range(0, 3);
                    hl = $urandom_range(0, 3);
                end
            endcase
            configure(wl, hl, $urandom_range(0, 3), $urandom_range(0, 1),
                      ($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(5, 7)), 4'($urandom()));
            size = pixel_count();
            load_frame();
            nfetch = $urandom_range(1, 2 * size + 2);
            for (int i = 0; i < nfetch; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_cmd(HGN_OP_LOAD, $urandom());
                queue_cmd(HGN_OP_FETCH, $urandom());
            end
            drain();
        end

        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // leftover expectations are caught by the drain wait
    initial
    begin
        wait (rst_n === 1'b1);
    end

endmodule

FILE: heightmap_gradient_normalizer_unit.f
rtl/hgn_pkg.sv
rtl/hgn_ram.sv
rtl/hgn_scale.sv
rtl/heightmap_gradient_normalizer_unit.sv
tb/testbench.sv
